FILE: rtl/core/sparse_column_matrix_assembler_macros.svh
// Assertion macros for the sparse column matrix assembler.
// Depends on a clock i_clk and an active-low reset i_rst_n in the including module.
`ifndef SPARSE_COLUMN_MATRIX_ASSEMBLER_MACROS_SVH
`define SPARSE_COLUMN_MATRIX_ASSEMBLER_MACROS_SVH

// Same-cycle implication.
`define SCMA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SCMA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/scma_pkg.sv
// Shared types and constants for the sparse column matrix assembler.
// No dependencies.
package scma_pkg;

    localparam int DATA_W     = 64;
    localparam int IDX_W      = 10;
    localparam int CMD_W      = 4;
    localparam int STAT_W     = 2;
    localparam int CFG_W      = 11;
    localparam int DEF_MAX_EQ = 1024;
    localparam int DEF_MAX_NZ = 8192;

    typedef enum logic [CMD_W-1:0] {
        CMD_RESET   = 4'd0,
        CMD_START   = 4'd1,
        CMD_INSERT  = 4'd2,
        CMD_ADD_MAT = 4'd3,
        CMD_ADD_RHS = 4'd4,
        CMD_CLR_MAT = 4'd5,
        CMD_CLR_RHS = 4'd6,
        CMD_RD_MAT  = 4'd7,
        CMD_RD_RHS  = 4'd8
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE    = 2'd0,
        ST_IGNORED = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_DEC, S_CS1, S_CS2, S_FRD, S_FCMP, S_MUL, S_NEG, S_RND,
        S_ADD, S_RDV, S_ST2, S_IRD, S_ICMP, S_SRD, S_SWR, S_IWR, S_OUT
    } t_state;

endpackage

FILE: rtl/core/sparse_column_matrix_assembler.sv
// Compressed-sparse-column matrix assembler with right-hand-side vector.
// Insert scans the column's rows for the insert point, then shifts later rows up a place;
// matrix read and add scan the column for the row. The row list memory port (one access
// per step) sets the column loop. Reset, reset structure and both clear commands run a
// pass over the value memories; reset takes no item until it ends.
// One item at a time; the next is accepted while a result waits in the output register.
`include "sparse_column_matrix_assembler_macros.svh"

module sparse_column_matrix_assembler
    import scma_pkg::*;
#(
    parameter int MAX_EQUATIONS = DEF_MAX_EQ,
    parameter int MAX_NONZEROS  = DEF_MAX_NZ
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // command[3:0], col_index[13:4], row_index[23:14], value[87:24], scale[151:88]
    input  logic [151:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // read_value[63:0], status[65:64], zero pad [71:66]
    output logic [71:0]  o_m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata
);

    localparam int NZW   = $clog2(MAX_NONZEROS + 1);
    localparam int NZA   = $clog2(MAX_NONZEROS);
    localparam int NW    = $clog2(MAX_EQUATIONS + 1);
    localparam int EA    = $clog2(MAX_EQUATIONS);
    localparam int SWEEP = (MAX_NONZEROS > MAX_EQUATIONS + 1) ? MAX_NONZEROS
                                                               : MAX_EQUATIONS + 1;
    localparam int SW    = $clog2(SWEEP + 1);

    // Memories
    logic [IDX_W-1:0]  row_mem [MAX_NONZEROS];
    logic [DATA_W-1:0] mat_mem [MAX_NONZEROS];
    logic [NZW-1:0]    cs_mem  [MAX_EQUATIONS+1];
    logic [DATA_W-1:0] rhs_mem [MAX_EQUATIONS];

    logic              row_we, row_re, mat_we, mat_re, cs_we, cs_re, rhs_we, rhs_re;
    logic [NZA-1:0]    row_wa, row_ra, mat_wa, mat_ra;
    logic [NW-1:0]     cs_wa, cs_ra;
    logic [EA-1:0]     rhs_wa, rhs_ra;
    logic [IDX_W-1:0]  row_wd, row_rd;
    logic [DATA_W-1:0] mat_wd, mat_rd, rhs_wd, rhs_rd;
    logic [NZW-1:0]    cs_wd, cs_rd;

    // Control and datapath registers
    t_state             r_state, n_state;
    logic [CMD_W-1:0]   r_cmd, n_cmd;
    logic [IDX_W-1:0]   r_col, n_col, r_row, n_row;
    logic [DATA_W-1:0]  r_val, n_val, r_scl, n_scl;
    logic [CFG_W-1:0]   r_numeq;
    logic [NZW-1:0]     r_fp, n_fp, r_k, n_k, r_e, n_e, r_j, n_j, r_ccs, n_ccs;
    logic [NW-1:0]      r_cc, n_cc;
    logic [DATA_W-1:0]  r_ma, n_ma, r_mb, n_mb, r_pp, n_pp, r_prod, n_prod;
    logic [DATA_W-1:0]  r_rd, n_rd;
    logic [127:0]       r_acc, n_acc;
    logic [2:0]         r_pi, n_pi;
    logic               r_neg, n_neg, r_tgt_rhs, n_tgt_rhs;
    logic [STAT_W-1:0]  r_st, n_st;
    logic [SW-1:0]      r_sweep, n_sweep;
    logic               r_clr_mat, n_clr_mat, r_clr_cs, n_clr_cs;
    logic               r_clr_rhs, n_clr_rhs, r_clr_lim, n_clr_lim;
    logic               r_boot, n_boot;
    logic               r_ovalid;
    logic [71:0]        r_odata;

    logic [NW-1:0]      eff_n;
    logic               in_take, out_load, sweep_last, row_ok, col_ok, found, gt_found;
    logic [127:0]       rnd_sum;
    logic [DATA_W-1:0]  old_val, add_sum, add_sat;

    // Effective size: register value clipped to capacity
    assign eff_n = (32'(r_numeq) < MAX_EQUATIONS) ? NW'(r_numeq) : NW'(MAX_EQUATIONS);

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_take    = i_s_axis_tvalid && o_s_axis_tready;
    assign out_load   = (r_state == S_OUT) && (!r_ovalid || i_m_axis_tready);
    assign sweep_last = (32'(r_sweep) == SWEEP - 1);
    assign row_ok     = (32'(r_row) < 32'(eff_n));
    assign col_ok     = (32'(r_col) < 32'(eff_n));
    assign found      = (row_rd == r_row);
    assign gt_found   = (row_rd > r_row);

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

    // Round to nearest (ties up) at bit 32, then check the kept window fits 64 bits
    assign rnd_sum = r_acc + 128'h8000_0000;
    assign old_val = r_tgt_rhs ? rhs_rd : mat_rd;
    assign add_sum = old_val + r_prod;
    always_comb begin
        if ((old_val[63] == r_prod[63]) && (add_sum[63] != old_val[63])) begin
            add_sat = old_val[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
            add_sat = add_sum;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR:  n_state = sweep_last ? (r_boot ? S_IDLE : S_OUT) : S_CLR;
            S_IDLE: n_state = in_take ? S_DEC : S_IDLE;
            S_DEC: begin
                case (r_cmd)
                    CMD_RESET, CMD_CLR_MAT, CMD_CLR_RHS: n_state = S_CLR;
                    CMD_START: begin
                        if (32'(r_cc) >= 32'(eff_n) || 32'(r_fp) >= MAX_NONZEROS) begin
                            n_state = S_OUT;
                        end else begin
                            n_state = S_ST2;
                        end
                    end
                    CMD_INSERT: begin
                        if (r_cc == '0 || 32'(r_fp) >= MAX_NONZEROS) begin
                            n_state = S_OUT;
                        end else begin
                            n_state = S_IRD;
                        end
                    end
                    CMD_ADD_MAT: n_state = (r_scl == '0 || !col_ok || !row_ok) ? S_OUT : S_CS1;
                    CMD_RD_MAT:  n_state = (!col_ok || !row_ok) ? S_OUT : S_CS1;
                    CMD_ADD_RHS: n_state = (r_scl == '0 || !row_ok) ? S_OUT : S_MUL;
                    CMD_RD_RHS:  n_state = row_ok ? S_RDV : S_OUT;
                    default:     n_state = S_OUT;
                endcase
            end
            S_CS1:  n_state = S_CS2;
            S_CS2:  n_state = S_FRD;
            S_FRD:  n_state = (r_k < r_e) ? S_FCMP : S_OUT;
            S_FCMP: begin
                if (!found) begin
                    n_state = S_FRD;
                end else begin
                    n_state = (r_cmd == CMD_RD_MAT) ? S_RDV : S_MUL;
                end
            end
            S_MUL:  n_state = (r_pi == 3'd4) ? S_NEG : S_MUL;
            S_NEG:  n_state = S_RND;
            S_RND:  n_state = S_ADD;
            S_ADD:  n_state = S_OUT;
            S_RDV:  n_state = S_OUT;
            S_ST2:  n_state = S_OUT;
            S_IRD:  n_state = (r_k < r_fp) ? S_ICMP : S_SRD;
            S_ICMP: n_state = gt_found ? S_SRD : S_IRD;
            S_SRD:  n_state = (r_k > r_j) ? S_SWR : S_IWR;
            S_SWR:  n_state = S_SRD;
            S_IWR:  n_state = S_OUT;
            S_OUT:  n_state = out_load ? S_IDLE : S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and memory controls
    always_comb begin
        n_cmd = r_cmd;  n_col = r_col;  n_row = r_row;  n_val = r_val;  n_scl = r_scl;
        n_fp = r_fp;    n_k = r_k;      n_e = r_e;      n_j = r_j;      n_ccs = r_ccs;
        n_cc = r_cc;    n_ma = r_ma;    n_mb = r_mb;    n_pp = r_pp;    n_prod = r_prod;
        n_rd = r_rd;    n_acc = r_acc;  n_pi = r_pi;    n_neg = r_neg;
        n_tgt_rhs = r_tgt_rhs;  n_st = r_st;  n_sweep = r_sweep;
        n_clr_mat = r_clr_mat;  n_clr_cs = r_clr_cs;
        n_clr_rhs = r_clr_rhs;  n_clr_lim = r_clr_lim;  n_boot = r_boot;
        row_we = 1'b0; row_wa = '0; row_wd = '0; row_re = 1'b0; row_ra = '0;
        mat_we = 1'b0; mat_wa = '0; mat_wd = '0; mat_re = 1'b0; mat_ra = '0;
        cs_we  = 1'b0; cs_wa  = '0; cs_wd  = '0; cs_re  = 1'b0; cs_ra  = '0;
        rhs_we = 1'b0; rhs_wa = '0; rhs_wd = '0; rhs_re = 1'b0; rhs_ra = '0;

        case (r_state)
            S_CLR: begin
                // Sweep one address a cycle across the value memories
                mat_we = r_clr_mat && (32'(r_sweep) < MAX_NONZEROS);
                mat_wa = r_sweep[NZA-1:0];
                cs_we  = r_clr_cs && (32'(r_sweep) <= MAX_EQUATIONS);
                cs_wa  = r_sweep[NW-1:0];
                rhs_we = r_clr_rhs && (32'(r_sweep) < MAX_EQUATIONS)
                         && (!r_clr_lim || 32'(r_sweep) < 32'(eff_n));
                rhs_wa = r_sweep[EA-1:0];
                n_sweep = r_sweep + 1'b1;
                if (sweep_last) begin
                    n_boot = 1'b0;
                end
            end
            S_IDLE: begin
                if (in_take) begin
                    n_cmd = i_s_axis_tdata[3:0];
                    n_col = i_s_axis_tdata[13:4];
                    n_row = i_s_axis_tdata[23:14];
                    n_val = i_s_axis_tdata[87:24];
                    n_scl = i_s_axis_tdata[151:88];
                end
            end
            S_DEC: begin
                n_st = ST_DONE;  n_rd = '0;  n_acc = '0;  n_pi = '0;
                n_neg = r_scl[63] ^ r_val[63];
                n_ma = r_scl[63] ? (~r_scl + 1'b1) : r_scl;
                n_mb = r_val[63] ? (~r_val + 1'b1) : r_val;
                n_sweep = '0;
                n_clr_mat = 1'b0; n_clr_cs = 1'b0; n_clr_rhs = 1'b0; n_clr_lim = 1'b0;
                case (r_cmd)
                    CMD_RESET: begin
                        n_fp = '0; n_cc = '0; n_ccs = '0;
                        n_clr_mat = 1'b1; n_clr_cs = 1'b1; n_clr_rhs = 1'b1;
                    end
                    CMD_CLR_MAT: n_clr_mat = 1'b1;
                    CMD_CLR_RHS: begin
                        n_clr_rhs = 1'b1; n_clr_lim = 1'b1;
                    end
                    CMD_START: begin
                        if (32'(r_cc) >= 32'(eff_n)) begin
                            n_st = ST_IGNORED;
                        end else if (32'(r_fp) >= MAX_NONZEROS) begin
                            n_st = ST_FULL;
                        end else begin
                            // The command's row opens the column
                            cs_we = 1'b1; cs_wa = r_cc; cs_wd = r_fp;
                            row_we = 1'b1; row_wa = r_fp[NZA-1:0]; row_wd = r_row;
                            n_ccs = r_fp;
                        end
                    end
                    CMD_INSERT: begin
                        if (r_cc == '0) begin
                            n_st = ST_IGNORED;
                        end else if (32'(r_fp) >= MAX_NONZEROS) begin
                            n_st = ST_FULL;
                        end else begin
                            n_k = r_ccs; n_j = r_fp;
                        end
                    end
                    CMD_ADD_MAT, CMD_RD_MAT: begin
                        if (r_cmd == CMD_ADD_MAT && r_scl == '0) begin
                            n_st = ST_DONE;
                        end else if (!col_ok || !row_ok) begin
                            n_st = ST_IGNORED;
                        end else begin
                            cs_re = 1'b1; cs_ra = NW'(r_col);
                        end
                    end
                    CMD_ADD_RHS, CMD_RD_RHS: begin
                        if (r_cmd == CMD_ADD_RHS && r_scl == '0) begin
                            n_st = ST_DONE;
                        end else if (!row_ok) begin
                            n_st = ST_IGNORED;
                        end else begin
                            rhs_re = 1'b1; rhs_ra = EA'(r_row); n_tgt_rhs = 1'b1;
                        end
                    end
                    default: n_st = ST_IGNORED;
                endcase
            end
            S_CS1: begin
                n_k = cs_rd;
                cs_re = 1'b1; cs_ra = NW'(r_col) + 1'b1;
            end
            S_CS2: n_e = (cs_rd > r_fp) ? r_fp : cs_rd;
            S_FRD: begin
                if (r_k < r_e) begin
                    row_re = 1'b1; row_ra = r_k[NZA-1:0];
                end else begin
                    n_st = ST_IGNORED;
                end
            end
            S_FCMP: begin
                if (found) begin
                    mat_re = 1'b1; mat_ra = r_k[NZA-1:0]; n_tgt_rhs = 1'b0;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_MUL: begin
                // One 32x32 partial product a cycle; add the previous one
                case (r_pi[1:0])
                    2'd0:    n_pp = r_ma[31:0]  * r_mb[31:0];
                    2'd1:    n_pp = r_ma[31:0]  * r_mb[63:32];
                    2'd2:    n_pp = r_ma[63:32] * r_mb[31:0];
                    default: n_pp = r_ma[63:32] * r_mb[63:32];
                endcase
                case (r_pi)
                    3'd1:       n_acc = r_acc + {64'd0, r_pp};
                    3'd2, 3'd3: n_acc = r_acc + {32'd0, r_pp, 32'd0};
                    3'd4:       n_acc = r_acc + {r_pp, 64'd0};
                    default:    n_acc = r_acc;
                endcase
                n_pi = r_pi + 1'b1;
            end
            S_NEG: begin
                if (r_neg) begin
                    n_acc = ~r_acc + 1'b1;
                end
            end
            S_RND: begin
                if (rnd_sum[127:95] == '0 || rnd_sum[127:95] == '1) begin
                    n_prod = rnd_sum[95:32];
                end else begin
                    n_prod = rnd_sum[127] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
                end
            end
            S_ADD: begin
                if (r_tgt_rhs) begin
                    rhs_we = 1'b1; rhs_wa = EA'(r_row); rhs_wd = add_sat;
                end else begin
                    mat_we = 1'b1; mat_wa = r_k[NZA-1:0]; mat_wd = add_sat;
                end
            end
            S_RDV: n_rd = r_tgt_rhs ? rhs_rd : mat_rd;
            S_ST2: begin
                cs_we = 1'b1; cs_wa = r_cc + 1'b1; cs_wd = r_fp + 1'b1;
                n_fp = r_fp + 1'b1;
                n_cc = r_cc + 1'b1;
            end
            S_IRD: begin
                if (r_k < r_fp) begin
                    row_re = 1'b1; row_ra = r_k[NZA-1:0];
                end else begin
                    n_k = r_fp;
                end
            end
            S_ICMP: begin
                if (gt_found) begin
                    n_j = r_k; n_k = r_fp;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_SRD: begin
                if (r_k > r_j) begin
                    row_re = 1'b1; row_ra = NZA'(r_k - 1'b1);
                end
            end
            S_SWR: begin
                // Shift one row up a place
                row_we = 1'b1; row_wa = r_k[NZA-1:0]; row_wd = row_rd;
                n_k = r_k - 1'b1;
            end
            S_IWR: begin
                row_we = 1'b1; row_wa = r_j[NZA-1:0]; row_wd = r_row;
                cs_we = 1'b1; cs_wa = r_cc; cs_wd = r_fp + 1'b1;
                n_fp = r_fp + 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (row_we) begin
            row_mem[row_wa] <= row_wd;
        end
        if (row_re) begin
            row_rd <= row_mem[row_ra];
        end
        if (mat_we) begin
            mat_mem[mat_wa] <= mat_wd;
        end
        if (mat_re) begin
            mat_rd <= mat_mem[mat_ra];
        end
        if (cs_we) begin
            cs_mem[cs_wa] <= cs_wd;
        end
        if (cs_re) begin
            cs_rd <= cs_mem[cs_ra];
        end
        if (rhs_we) begin
            rhs_mem[rhs_wa] <= rhs_wd;
        end
        if (rhs_re) begin
            rhs_rd <= rhs_mem[rhs_ra];
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;  r_col <= n_col;  r_row <= n_row;  r_val <= n_val;
        r_scl <= n_scl;  r_k <= n_k;      r_e <= n_e;      r_j <= n_j;
        r_ma <= n_ma;    r_mb <= n_mb;    r_pp <= n_pp;    r_prod <= n_prod;
        r_rd <= n_rd;    r_acc <= n_acc;  r_pi <= n_pi;    r_neg <= n_neg;
        r_tgt_rhs <= n_tgt_rhs;  r_st <= n_st;
        if (out_load) begin
            r_odata <= {6'd0, r_st, r_rd};
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_boot    <= 1'b1;
            r_sweep   <= '0;
            r_clr_mat <= 1'b1;
            r_clr_cs  <= 1'b1;
            r_clr_rhs <= 1'b1;
            r_clr_lim <= 1'b0;
            r_fp      <= '0;
            r_cc      <= '0;
            r_ccs     <= '0;
            r_numeq   <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_boot    <= n_boot;
            r_sweep   <= n_sweep;
            r_clr_mat <= n_clr_mat;
            r_clr_cs  <= n_clr_cs;
            r_clr_rhs <= n_clr_rhs;
            r_clr_lim <= n_clr_lim;
            r_fp      <= n_fp;
            r_cc      <= n_cc;
            r_ccs     <= n_ccs;
            if (i_cfg_we) begin
                r_numeq <= i_cfg_wdata;
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    `SCMA_ASSERT_NOW(a_fp_cap, 1'b1, 32'(r_fp) <= MAX_NONZEROS, "fill pointer over capacity")
    `SCMA_ASSERT_NOW(a_ccs_fp, 1'b1, r_ccs <= r_fp, "column start beyond fill pointer")
    `SCMA_ASSERT_NOW(a_scan_rng, r_state == S_FCMP, r_k < r_e, "scan past column end")
    `SCMA_ASSERT_NEXT(a_ins_fp, r_state == S_IWR, r_fp == NZW'($past(r_fp) + 1'b1), "insert count")

endmodule
